[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion shorthands
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/core/cbd_pkg.sv]
// ----------------------------------------------------------------------------
// cbd_pkg: shared types and codes of the deque
// command and status codes, word type and the per-cycle shift control
// ----------------------------------------------------------------------------
package cbd_pkg;

    localparam int WORD_W = 32;
    localparam int OCC_W  = 8;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [2:0] {
        CMD_QUERY      = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_PUSH_BACK  = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_BACK   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // at most one bit set; only for commands that are carried out
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
    } cbd_op_t;

endpackage

[rtl/core/circular_buffer_deque.sv]
// timing: a result is strobed on done in the cycle after its command transfer
// throughput: one command per cycle, busy is never raised
// the deque is a chain of cells, each cell updated by its neighbors
// reset (rst_n low, asynchronous) empties the deque; stored words are not cleared
// results cannot be stalled; each result is valid for the single done cycle
// ----------------------------------------------------------------------------
// circular_buffer_deque: double-ended queue of signed 32-bit words
// push/pop at either end with full/empty refusal, reports both end words
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module circular_buffer_deque
    import cbd_pkg::*;
#(
    parameter int CAPACITY = 128
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        cmd,
    input  logic signed [31:0] value,
    output logic              done,
    output logic [1:0]        status,
    output logic signed [31:0] front_word,
    output logic signed [31:0] back_word,
    output logic [7:0]        occupancy,
    output logic              is_empty
);

    localparam int CNT_W = $clog2(CAPACITY) + 1;

    // the content is held twice in two rows of the same cells:
    //   f row: front word at cell 0, back word at cell count-1
    //   b row: back word at cell 0, front word at cell count-1
    // a push at one end shifts that end's row toward higher cells and
    // drops the word into the first free cell of the other row; a pop
    // shifts the row of its end toward cell 0 and just shortens the other.
    // the valid bits form a thermometer shared by both rows, so each cell
    // decides from itself and its two neighbors alone

    cbd_op_t          op;
    logic [CNT_W-1:0] count;
    logic [CAPACITY-1:0] valid_vec;
    word_t            f_arr [CAPACITY];
    word_t            b_arr [CAPACITY];

    // no wait states: a command transfer can happen every cycle
    assign busy = 1'b0;

    cbd_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .full   (valid_vec[CAPACITY-1]),
        .empty  (~valid_vec[0]),
        .op     (op),
        .done   (done),
        .status (status),
        .count  (count)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        word_t lf;
        word_t rf;
        word_t lb;
        word_t rb;
        logic  lv;
        logic  rv;

        // cell 0 takes the pushed word, beyond it the chain is always full
        if (i == 0)
        begin : g_first
            assign lf = value;
            assign lb = value;
            assign lv = 1'b1;
        end
        else
        begin : g_mid_left
            assign lf = f_arr[i-1];
            assign lb = b_arr[i-1];
            assign lv = valid_vec[i-1];
        end

        // past the last cell nothing is held
        if (i == CAPACITY - 1)
        begin : g_last
            assign rf = '0;
            assign rb = '0;
            assign rv = 1'b0;
        end
        else
        begin : g_mid_right
            assign rf = f_arr[i+1];
            assign rb = b_arr[i+1];
            assign rv = valid_vec[i+1];
        end

        cbd_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (op),
            .value       (value),
            .left_f      (lf),
            .right_f     (rf),
            .left_b      (lb),
            .right_b     (rb),
            .left_valid  (lv),
            .right_valid (rv),
            .f_word      (f_arr[i]),
            .b_word      (b_arr[i]),
            .valid       (valid_vec[i])
        );
    end

    // end words come straight from cell 0 of each row, forced to zero when empty
    assign front_word = valid_vec[0] ? f_arr[0] : '0;
    assign back_word  = valid_vec[0] ? b_arr[0] : '0;
    assign occupancy  = OCC_W'(count);
    assign is_empty   = ~valid_vec[0];

    `ASSERT_CLK(a_empty_match, (count == '0) == !valid_vec[0],
        "deque: count and occupancy bits disagree on empty")
    `ASSERT_CLK(a_full_match, (count == CNT_W'(CAPACITY)) == valid_vec[CAPACITY-1],
        "deque: count and occupancy bits disagree on full")
    `ASSERT_IMPL(a_push_front_word,
        done && status == ST_DONE && $past(cmd) == CMD_PUSH_FRONT,
        front_word == $past(value), "deque: pushed word not at front")

endmodule

[rtl/core/cbd_cell.sv]
// ----------------------------------------------------------------------------
// cbd_cell: one position of the deque chain
// holds one word of the front-ordered row, one of the back-ordered row
// and an occupancy bit
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbd_cell
    import cbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cbd_op_t op,
    input  word_t   value,
    input  word_t   left_f,
    input  word_t   right_f,
    input  word_t   left_b,
    input  word_t   right_b,
    input  logic    left_valid,
    input  logic    right_valid,
    output word_t   f_word,
    output word_t   b_word,
    output logic    valid
);

    word_t f_reg;
    word_t f_next;
    word_t b_reg;
    word_t b_next;
    logic  valid_reg;
    logic  valid_next;
    logic  first_empty;

    // this cell is the first free slot
    assign first_empty = left_valid & ~valid_reg;

    always_comb
    begin
        f_next     = f_reg;
        b_next     = b_reg;
        valid_next = valid_reg;
        unique if (op.push_front)
        begin
            f_next     = left_f;
            valid_next = left_valid;
            if (first_empty)
            begin
                b_next = value;
            end
        end
        else if (op.push_back)
        begin
            b_next     = left_b;
            valid_next = left_valid;
            if (first_empty)
            begin
                f_next = value;
            end
        end
        else if (op.pop_front)
        begin
            f_next     = right_f;
            valid_next = right_valid;
        end
        else if (op.pop_back)
        begin
            b_next     = right_b;
            valid_next = right_valid;
        end
        else
        begin
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg <= f_next;
        b_reg <= b_next;
    end

    assign f_word = f_reg;
    assign b_word = b_reg;
    assign valid  = valid_reg;

    // occupied cells stay packed against cell 0
    `ASSERT_IMPL(a_cell_packed, valid_reg, left_valid, "cbd_cell: hole in occupied run")

endmodule

[rtl/core/cbd_ctrl.sv]
// ----------------------------------------------------------------------------
// cbd_ctrl: command decode and result status
// refuses push when full and pop when empty, keeps the word count
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbd_ctrl
    import cbd_pkg::*;
#(
    parameter int CAPACITY = 128,
    localparam int CNT_W   = $clog2(CAPACITY) + 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [2:0]       cmd,
    input  logic             full,
    input  logic             empty,
    output cbd_op_t          op,
    output logic             done,
    output logic [1:0]       status,
    output logic [CNT_W-1:0] count
);

    cbd_op_t          op_c;
    status_t          status_next;
    status_t          status_reg;
    logic             done_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        op_c        = '0;
        status_next = ST_DONE;
        count_next  = count_reg;
        if (start)
        begin
            unique case (cmd)
                CMD_PUSH_FRONT, CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        op_c.push_front = (cmd == CMD_PUSH_FRONT);
                        op_c.push_back  = (cmd == CMD_PUSH_BACK);
                        count_next      = count_reg + CNT_W'(1);
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        op_c.pop_front = (cmd == CMD_POP_FRONT);
                        op_c.pop_back  = (cmd == CMD_POP_BACK);
                        count_next     = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    // query and unused codes change nothing
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            status_reg <= ST_DONE;
            count_reg  <= '0;
        end
        else
        begin
            done_reg  <= start;
            count_reg <= count_next;
            if (start)
            begin
                status_reg <= status_next;
            end
        end
    end

    assign op     = op_c;
    assign done   = done_reg;
    assign status = status_reg;
    assign count  = count_reg;

    `ASSERT_CLK(a_op_onehot, $onehot0(op_c), "cbd_ctrl: more than one shift op")
    `ASSERT_IMPL(a_refused_keeps_count, done && status_reg != ST_DONE,
        count_reg == $past(count_reg), "cbd_ctrl: refused command changed count")

endmodule

[test/tb_circular_buffer_deque.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_buffer_deque: self-checking bench for the double-ended queue
// a directed table, then random fill/drain phases; results are checked against
// fixed table views or a local deque predictor, with random idle gaps on the command side
// ----------------------------------------------------------------------------
module tb_circular_buffer_deque;
    import cbd_pkg::*;

    localparam int DEPTH          = 128;
    localparam int IDX_W          = $clog2(DEPTH);
    localparam int IDLE_LIMIT     = 1000;
    localparam int N_DIRECTED     = 22;
    localparam int N_PHASES       = 4;

    // command codes the block does not define; it treats them as a query
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    localparam word_t WORD_MAX = 32'sh7fffffff;
    localparam word_t WORD_MIN = 32'sh80000000;

    // what one result reports about the deque
    typedef struct packed {
        status_t     status;
        word_t       front;
        word_t       back;
        logic [7:0]  occ;
        logic        empty;
    } deque_view_t;

    // one directed command; view is only used where has_view is set
    typedef struct {
        logic [2:0]  op;
        word_t       val;
        bit          has_view;
        deque_view_t view;
    } stim_row_t;

    localparam deque_view_t NO_VIEW = '{ST_DONE, 32'sd0, 32'sd0, 8'd0, 1'b0};
    localparam deque_view_t EMPTY_VIEW = '{ST_DONE, 32'sd0, 32'sd0, 8'd0, 1'b1};
    localparam deque_view_t REFUSED_EMPTY = '{ST_EMPTY, 32'sd0, 32'sd0, 8'd0, 1'b1};
    localparam deque_view_t TWO_EXTREMES = '{ST_DONE, WORD_MIN, WORD_MAX, 8'd2, 1'b0};

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  cmd   = CMD_QUERY;
    word_t       value = '0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    word_t       front_word;
    word_t       back_word;
    logic [7:0]  occupancy;
    logic        is_empty;

    // predictor state: ring, front and rear pointers, word count
    word_t            model_ring [DEPTH];
    logic [IDX_W-1:0] front_idx = '0;
    logic [IDX_W-1:0] rear_idx  = '0;
    int unsigned      held      = 0;

    deque_view_t pending_views [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    bit          gaps_on     = 1'b1;

    // directed table: extremes, refusals, unused codes, pointer wrap at the front
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{CMD_QUERY,      32'sd0,          1'b1, EMPTY_VIEW},
        '{CMD_POP_FRONT,  32'sd0,          1'b1, REFUSED_EMPTY},
        '{CMD_POP_BACK,   32'sd0,          1'b1, REFUSED_EMPTY},
        '{CMD_PUSH_BACK,  WORD_MAX,        1'b1,
          '{ST_DONE, WORD_MAX, WORD_MAX, 8'd1, 1'b0}},
        '{CMD_PUSH_FRONT, WORD_MIN,        1'b1, TWO_EXTREMES},
        '{CMD_QUERY,      -32'sd1,         1'b1, TWO_EXTREMES},
        '{CMD_RSVD5,      32'sh5a5a5a5a,   1'b1, TWO_EXTREMES},
        '{CMD_RSVD6,      32'sha5a5a5a5,   1'b0, NO_VIEW},
        '{CMD_RSVD7,      -32'sd1,         1'b0, NO_VIEW},
        '{CMD_PUSH_BACK,  -32'sd1,         1'b0, NO_VIEW},
        '{CMD_PUSH_FRONT, 32'sd0,          1'b0, NO_VIEW},
        '{CMD_POP_BACK,   32'sd0,          1'b0, NO_VIEW},
        '{CMD_POP_FRONT,  32'sd0,          1'b0, NO_VIEW},
        '{CMD_POP_BACK,   32'sd0,          1'b0, NO_VIEW},
        '{CMD_POP_FRONT,  32'sd0,          1'b0, NO_VIEW},
        '{CMD_POP_BACK,   -32'sd1,         1'b1, REFUSED_EMPTY},
        '{CMD_PUSH_FRONT, 32'sd1,          1'b0, NO_VIEW},
        '{CMD_POP_BACK,   32'sd0,          1'b0, NO_VIEW},
        '{CMD_PUSH_BACK,  32'sh55555555,   1'b0, NO_VIEW},
        '{CMD_PUSH_BACK,  32'shaaaaaaaa,   1'b0, NO_VIEW},
        '{CMD_POP_FRONT,  32'sd0,          1'b0, NO_VIEW},
        '{CMD_POP_FRONT,  32'sd0,          1'b0, NO_VIEW}
    };

    // random phases: fill to full, drain to empty, fill again, then churn
    int phase_push  [N_PHASES] = '{93, 5, 93, 45};
    int phase_pop   [N_PHASES] = '{5, 93, 5, 45};
    int phase_items [N_PHASES] = '{160, 160, 160, 120};

    circular_buffer_deque #(
        .CAPACITY   (DEPTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .value      (value),
        .done       (done),
        .status     (status),
        .front_word (front_word),
        .back_word  (back_word),
        .occupancy  (occupancy),
        .is_empty   (is_empty)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // carries out one command on the local deque and returns the view after it
    function automatic deque_view_t apply_deque_cmd(input logic [2:0] op, input word_t val);
        deque_view_t      v;
        logic [IDX_W-1:0] last_idx;
        v        = NO_VIEW;
        v.status = ST_DONE;
        case (op)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (held == DEPTH)
                    v.status = ST_FULL;
                else if (op == CMD_PUSH_FRONT)
                begin
                    front_idx             = front_idx - 1'b1;
                    model_ring[front_idx] = val;
                    held++;
                end
                else
                begin
                    model_ring[rear_idx] = val;
                    rear_idx             = rear_idx + 1'b1;
                    held++;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (held == 0)
                    v.status = ST_EMPTY;
                else if (op == CMD_POP_FRONT)
                begin
                    front_idx = front_idx + 1'b1;
                    held--;
                end
                else
                begin
                    rear_idx = rear_idx - 1'b1;
                    held--;
                end
            end
            default: ;  // query and unused codes leave the deque alone
        endcase
        last_idx = rear_idx - 1'b1;
        // both end words read zero once the deque is empty
        v.front  = (held != 0) ? model_ring[front_idx] : 32'sd0;
        v.back   = (held != 0) ? model_ring[last_idx] : 32'sd0;
        v.occ    = held[7:0];
        v.empty  = (held == 0);
        return v;
    endfunction

    // mostly pushes or pops at random ends, with a little noise over all codes
    function automatic logic [2:0] pick_cmd(input int push_pct, input int pop_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        if (roll < push_pct + pop_pct)
            return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic word_t pick_word();
        case ($urandom_range(0, 7))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return -32'sd1;
            default: return word_t'($urandom());
        endcase
    endfunction

    // idle gap, then hold start until the transfer, then queue its expectation
    task automatic send_cmd(input logic [2:0] op, input word_t val,
                            input bit has_view, input deque_view_t view);
        int          gap;
        deque_view_t predicted;
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= op;
        value <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // the transfer happened at this edge
        predicted = apply_deque_cmd(op, val);
        pending_views.push_back(has_view ? view : predicted);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        error_count++;
    endtask

    // result side: every done strobe is matched with the oldest expectation
    always @(posedge clk)
    begin
        deque_view_t want;
        if (rst_n && done)
        begin
            if (pending_views.size() == 0)
            begin
                $display("%0t: result with nothing expected, got status %h occupancy %h",
                         $time, status, occupancy);
                error_count++;
            end
            else
            begin
                want = pending_views.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(status));
                if (front_word !== want.front)
                    report_mismatch("front_word", want.front, front_word);
                if (back_word !== want.back)
                    report_mismatch("back_word", want.back, back_word);
                if (occupancy !== want.occ)
                    report_mismatch("occupancy", 32'(want.occ), 32'(occupancy));
                if (is_empty !== want.empty)
                    report_mismatch("is_empty", 32'(want.empty), 32'(is_empty));
            end
        end
    end

    // watchdog: too long without any command or result transfer
    always @(posedge clk)
    begin
        if ((rst_n && start && !busy) || (rst_n && done))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: timeout, no transfer for %0d cycles", $time, idle_cycles);
            $display("tb_circular_buffer_deque NOT OK");
            $finish;
        end
    end

    initial
    begin
        int n;
        n = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[i])
        begin
            if (n % 40 == 0)
                gaps_on = $urandom_range(0, 1);
            send_cmd(directed_rows[i].op, directed_rows[i].val,
                     directed_rows[i].has_view, directed_rows[i].view);
            n++;
        end

        // random phases, gaps switched on and off in stretches of 40 commands
        for (int p = 0; p < N_PHASES; p++)
        begin
            for (int k = 0; k < phase_items[p]; k++)
            begin
                if (n % 40 == 0)
                    gaps_on = $urandom_range(0, 1);
                send_cmd(pick_cmd(phase_push[p], phase_pop[p]), pick_word(), 1'b0, NO_VIEW);
                n++;
            end
        end
        start <= 1'b0;

        // drain outstanding results, then keep watching to catch stray strobes
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (error_count == 0)
            $display("tb_circular_buffer_deque OK");
        else
            $display("tb_circular_buffer_deque NOT OK");
        $finish;
    end

endmodule
